/* hw/rtl/skvt_pkg.sv */
// Package: types, codes and helpers of the sorted key/value table
package skvt_pkg;

    localparam logic [1:0] FUNC_PUT  = 2'd0;
    localparam logic [1:0] FUNC_GET  = 2'd1;
    localparam logic [1:0] FUNC_DEL  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FIRST   = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_INS_RD,
        ST_INS_WR,
        ST_INSERT,
        ST_DEL_RD,
        ST_DEL_WR
    } skvt_state_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] value;
    } skvt_entry_t;

    typedef struct packed {
        logic        en;
        skvt_entry_t data;
    } skvt_wr_t;

    // keep at most nchars leading characters, drop everything from the first NUL
    function automatic logic [63:0] trim_word(input logic [63:0] word,
                                              input logic [3:0]  nchars);
        logic [63:0] out;
        logic        alive;
        logic [7:0]  ch;
        out   = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            ch    = word[63 - 8 * i -: 8];
            alive = alive & (4'(i) < nchars) & (ch != 8'd0);
            if (alive)
            begin
                out[63 - 8 * i -: 8] = ch;
            end
        end
        return out;
    endfunction

endpackage

/* hw/rtl/skvt_store.sv */
// Entry memory: one write port, one read port with registered read data
module skvt_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  skvt_pkg::skvt_wr_t   wr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [AW-1:0]        rd_addr,
    output skvt_pkg::skvt_entry_t rd_data
);

    skvt_pkg::skvt_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/sorted_key_value_table_unit.sv */
// Top level: sorted key/value table with a sequenced search and shift engine
//
//  channel   ports                          handshake
//  -------   -----------------------------  -------------------------------
//  command   func, key, value_in            start high while busy low
//  result    status, value_out              done high for one cycle
//
// The time a transaction takes grows with the number of stored entries: the entry memory has
// registered read data, so each entry visited costs a read and a compare (search) or a read
// and a write (shift).
// busy is high until the result shows; an unused code or a put on a full table answers at once.
// Reset clears the entry count, the state and the done flag only; the memory needs no clearing pass.
// The receiver cannot stall: done marks each result for exactly one cycle.
module sorted_key_value_table_unit #(
    parameter int DEPTH       = 32,
    parameter int KEY_CHARS   = 8,
    parameter int VALUE_CHARS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [63:0] key,
    input  logic [63:0] value_in,
    output logic        done,
    output logic [1:0]  status,
    output logic [63:0] value_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    skvt_pkg::skvt_state_t state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [1:0]     func_reg, func_next;
    logic [63:0]    key_reg, key_next;
    logic [63:0]    val_reg, val_next;
    logic           done_reg, done_next;
    logic [1:0]     status_reg, status_next;
    logic [63:0]    vout_reg, vout_next;

    logic [CW-1:0]  j_m1, j_p1;
    logic           at_end, key_lt, key_eq, full, start_ok;

    skvt_pkg::skvt_wr_t    wr;
    logic [AW-1:0]         wr_addr, rd_addr;
    skvt_pkg::skvt_entry_t rd_data;

    skvt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign j_m1     = j_reg - CW'(1);
    assign j_p1     = j_reg + CW'(1);
    assign at_end   = (idx_reg == count_reg);
    assign key_lt   = (rd_data.key < key_reg);
    assign key_eq   = (rd_data.key == key_reg);
    assign full     = (count_reg == CW'(DEPTH));
    assign start_ok = start && (func != skvt_pkg::FUNC_NONE)
                      && !((func == skvt_pkg::FUNC_PUT) && full);

    assign busy      = (state_reg != skvt_pkg::ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = vout_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                if (start_ok)
                begin
                    state_next = skvt_pkg::ST_SEARCH;
                end
            end
            skvt_pkg::ST_SEARCH:
            begin
                if (!at_end)
                begin
                    state_next = skvt_pkg::ST_CMP;
                end
                else if (func_reg == skvt_pkg::FUNC_PUT)
                begin
                    state_next = skvt_pkg::ST_INSERT;
                end
                else
                begin
                    state_next = skvt_pkg::ST_IDLE;
                end
            end
            skvt_pkg::ST_CMP:
            begin
                if (key_lt)
                begin
                    state_next = skvt_pkg::ST_SEARCH;
                end
                else if (func_reg == skvt_pkg::FUNC_PUT)
                begin
                    state_next = skvt_pkg::ST_INS_RD;
                end
                else if (key_eq && (func_reg == skvt_pkg::FUNC_DEL))
                begin
                    state_next = skvt_pkg::ST_DEL_RD;
                end
                else
                begin
                    state_next = skvt_pkg::ST_IDLE;
                end
            end
            skvt_pkg::ST_INS_RD:
            begin
                state_next = skvt_pkg::ST_INS_WR;
            end
            skvt_pkg::ST_INS_WR:
            begin
                state_next = (j_m1 == idx_reg) ? skvt_pkg::ST_INSERT : skvt_pkg::ST_INS_RD;
            end
            skvt_pkg::ST_INSERT:
            begin
                state_next = skvt_pkg::ST_IDLE;
            end
            skvt_pkg::ST_DEL_RD:
            begin
                state_next = (j_p1 >= count_reg) ? skvt_pkg::ST_IDLE : skvt_pkg::ST_DEL_WR;
            end
            skvt_pkg::ST_DEL_WR:
            begin
                state_next = skvt_pkg::ST_DEL_RD;
            end
            default:
            begin
                state_next = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        vout_next   = vout_reg;
        rd_addr     = idx_reg[AW-1:0];
        wr_addr     = j_reg[AW-1:0];
        wr.en       = 1'b0;
        wr.data     = rd_data;
        case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    key_next  = skvt_pkg::trim_word(key, 4'(KEY_CHARS));
                    val_next  = skvt_pkg::trim_word(value_in, 4'(VALUE_CHARS));
                    idx_next  = '0;
                    vout_next = '0;
                    if (func == skvt_pkg::FUNC_NONE)
                    begin
                        done_next   = 1'b1;
                        status_next = skvt_pkg::STATUS_DONE;
                    end
                    else if ((func == skvt_pkg::FUNC_PUT) && full)
                    begin
                        done_next   = 1'b1;
                        status_next = skvt_pkg::STATUS_FULL;
                    end
                end
            end
            skvt_pkg::ST_SEARCH:
            begin
                if (at_end && (func_reg != skvt_pkg::FUNC_PUT))
                begin
                    done_next   = 1'b1;
                    status_next = skvt_pkg::STATUS_MISSING;
                end
            end
            skvt_pkg::ST_CMP:
            begin
                if (key_lt)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else if (func_reg == skvt_pkg::FUNC_PUT)
                begin
                    j_next = count_reg;
                end
                else if (!key_eq)
                begin
                    done_next   = 1'b1;
                    status_next = skvt_pkg::STATUS_MISSING;
                end
                else if (func_reg == skvt_pkg::FUNC_GET)
                begin
                    done_next   = 1'b1;
                    status_next = skvt_pkg::STATUS_DONE;
                    vout_next   = rd_data.value;
                end
                else
                begin
                    j_next = idx_reg;
                end
            end
            skvt_pkg::ST_INS_RD:
            begin
                rd_addr = j_m1[AW-1:0];
            end
            skvt_pkg::ST_INS_WR:
            begin
                wr.en  = 1'b1;
                j_next = j_m1;
            end
            skvt_pkg::ST_INSERT:
            begin
                wr.en         = 1'b1;
                wr_addr       = idx_reg[AW-1:0];
                wr.data.key   = key_reg;
                wr.data.value = val_reg;
                count_next    = count_reg + CW'(1);
                done_next     = 1'b1;
                status_next   = (count_reg == '0) ? skvt_pkg::STATUS_FIRST
                                                  : skvt_pkg::STATUS_DONE;
            end
            skvt_pkg::ST_DEL_RD:
            begin
                rd_addr = j_p1[AW-1:0];
                if (j_p1 >= count_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = skvt_pkg::STATUS_DONE;
                end
            end
            skvt_pkg::ST_DEL_WR:
            begin
                wr.en  = 1'b1;
                j_next = j_p1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skvt_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        func_reg   <= func_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
    end

endmodule
